// ===== rtl/core/tfpid_pkg.sv =====
// tfpid_pkg: shared types, constants and tables for the tilt filter pid controller
// depends on nothing

package tfpid_pkg;

  localparam int CordicSteps = 16;
  localparam int StepW = $clog2(CordicSteps + 1);
  localparam int AngMax = 46080;

  typedef enum logic [2:0] {
    CFG_PROP   = 3'd0,
    CFG_INTEG  = 3'd1,
    CFG_DERIV  = 3'd2,
    CFG_TARGET = 3'd3,
    CFG_LIMIT  = 3'd4,
    CFG_DIS    = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PRE, ST_CORDIC, ST_ROUND, ST_FUSE, ST_DIV, ST_ERR,
    ST_INTEG, ST_TOTAL, ST_CLAMP, ST_MAG, ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic pre;
    logic step;
    logic round;
    logic fuse;
    logic div;
    logic err;
    logic integ;
    logic total;
    logic clamp;
    logic mag;
  } dp_cmd_t;

  typedef struct packed {
    logic cordic_done;
    logic div_done;
  } dp_sts_t;

  function automatic logic signed [27:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0: atan_lut = 28'sd2949120;
      5'd1: atan_lut = 28'sd1740967;
      5'd2: atan_lut = 28'sd919879;
      5'd3: atan_lut = 28'sd466945;
      5'd4: atan_lut = 28'sd234379;
      5'd5: atan_lut = 28'sd117304;
      5'd6: atan_lut = 28'sd58666;
      5'd7: atan_lut = 28'sd29335;
      5'd8: atan_lut = 28'sd14668;
      5'd9: atan_lut = 28'sd7334;
      5'd10: atan_lut = 28'sd3667;
      5'd11: atan_lut = 28'sd1833;
      5'd12: atan_lut = 28'sd917;
      5'd13: atan_lut = 28'sd458;
      5'd14: atan_lut = 28'sd229;
      5'd15: atan_lut = 28'sd115;
      5'd16: atan_lut = 28'sd57;
      5'd17: atan_lut = 28'sd29;
      5'd18: atan_lut = 28'sd14;
      5'd19: atan_lut = 28'sd7;
      5'd20: atan_lut = 28'sd4;
      5'd21: atan_lut = 28'sd2;
      5'd22: atan_lut = 28'sd1;
      default: atan_lut = 28'sd0;
    endcase
  endfunction

endpackage

// ===== rtl/core/tfpid_ctrl.sv =====
// tfpid_ctrl: sequencer that steps the datapath through one sample
// depends on tfpid_pkg

module tfpid_ctrl import tfpid_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_PRE;
      ST_PRE:    state_d = ST_CORDIC;
      ST_CORDIC: if (sts_i.cordic_done) state_d = ST_ROUND;
      ST_ROUND:  state_d = ST_FUSE;
      ST_FUSE:   state_d = ST_DIV;
      ST_DIV:    if (sts_i.div_done) state_d = ST_ERR;
      ST_ERR:    state_d = ST_INTEG;
      ST_INTEG:  state_d = ST_TOTAL;
      ST_TOTAL:  state_d = ST_CLAMP;
      ST_CLAMP:  state_d = ST_MAG;
      ST_MAG:    state_d = ST_OUT;
      ST_OUT: begin
        if (!out_stall_i) begin
          if (in_valid_i) state_d = ST_PRE;
          else state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_PRE:    cmd_o.pre = 1'b1;
      ST_CORDIC: cmd_o.step = 1'b1;
      ST_ROUND:  cmd_o.round = 1'b1;
      ST_FUSE:   cmd_o.fuse = 1'b1;
      ST_DIV:    cmd_o.div = 1'b1;
      ST_ERR:    cmd_o.err = 1'b1;
      ST_INTEG:  cmd_o.integ = 1'b1;
      ST_TOTAL:  cmd_o.total = 1'b1;
      ST_CLAMP:  cmd_o.clamp = 1'b1;
      ST_MAG:    cmd_o.mag = 1'b1;
      ST_OUT: begin
        out_valid_o = 1'b1;
        in_stall_o = out_stall_i;
        cmd_o.load = in_valid_i && !out_stall_i;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/tfpid_dp.sv =====
// tfpid_dp: cordic, complementary filter, reciprocal divider and pid arithmetic
// depends on tfpid_pkg

module tfpid_dp import tfpid_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_sts_t            sts_o,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic signed [15:0] gyro_x_i,
  input  logic [15:0]        prop_gain_i,
  input  logic [15:0]        integ_gain_i,
  input  logic [15:0]        deriv_gain_i,
  input  logic signed [16:0] target_angle_i,
  input  logic [7:0]         power_limit_i,
  input  logic               motors_disabled_i,
  output logic [7:0]         drive_magnitude_o,
  output logic               drive_reverse_o,
  output logic signed [16:0] tilt_angle_o
);

  localparam logic signed [27:0] Quarter = 28'sd5898240;
  localparam logic signed [39:0] IntMax = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] IntMin = {1'b1, {39{1'b0}}};
  localparam logic [22:0] UnitPwr = 23'd6553600;
  // filter divisor is 4 * 81875, reciprocal of 81875 scaled by 2^32
  localparam logic [16:0] Div81875 = 17'd81875;
  localparam logic [15:0] Recip = 16'd52457;
  // reciprocal of 100 scaled by 2^19
  localparam logic [12:0] MagRecip = 13'd5243;

  logic signed [15:0] gx_q;
  logic               zero_q;
  logic signed [26:0] x_q, y_q;
  logic signed [27:0] ang_q;
  logic [StepW-1:0]   it_q;
  logic signed [16:0] acc_q, cur_q, prev_q;
  logic signed [17:0] err_q;
  logic signed [39:0] num_q;
  logic [1:0]         ph_q;
  logic [31:0]        a_q;
  logic               lo_q;
  logic [15:0]        quo_q;
  logic [17:0]        rem_q;
  logic               neg_q;
  logic signed [39:0] integ_q, pterm_q, dterm_q;
  logic signed [49:0] total_q;
  logic signed [49:0] lim_q;
  logic               rev_q;
  logic [7:0]         mag_q;

  logic signed [26:0] x0, y0, dx, dy;
  logic signed [27:0] ang_r;
  logic signed [40:0] num_adj;
  logic [40:0]        num_abs;
  logic [47:0]        qe_prod;
  logic [32:0]        rem_full;
  logic [16:0]        quo_up;
  logic signed [40:0] integ_sum;
  logic signed [17:0] dang;
  logic signed [49:0] mag_abs;
  logic [15:0]        mag_b;
  logic [28:0]        mag_prod;

  assign x0 = 27'(accel_z_i) <<< 8;
  assign y0 = 27'(accel_y_i) <<< 8;
  assign dx = y_q >>> it_q;
  assign dy = x_q >>> it_q;
  assign ang_r = (ang_q + 28'sd128) >>> 8;
  assign num_adj = 41'(num_q) + 41'sd163750;
  assign num_abs = num_adj[40] ? -num_adj : num_adj;
  assign qe_prod = 48'(a_q) * 48'(Recip);
  assign rem_full = 33'(a_q) - 33'(quo_q) * 33'(Div81875);
  assign quo_up = 17'(quo_q) + 17'((rem_q != '0) || lo_q);
  assign integ_sum = 41'(integ_q) + 41'($signed({1'b0, integ_gain_i})) * 41'(err_q);
  assign dang = 18'(cur_q) - 18'(prev_q);
  assign mag_abs = total_q[49] ? -total_q : total_q;
  assign mag_b = 16'((mag_abs[33:0] + 34'd3276800) >> 16);
  assign mag_prod = 29'(mag_b) * 29'(MagRecip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      integ_q <= '0;
      it_q <= '0;
      ph_q <= '0;
    end else begin
      if (cmd_i.load) begin
        gx_q <= gyro_x_i;
        zero_q <= (accel_y_i == 16'sd0) && (accel_z_i == 16'sd0);
        x_q <= x0;
        y_q <= y0;
      end
      if (cmd_i.pre) begin
        it_q <= '0;
        if (x_q < 0) begin
          if (y_q >= 0) begin
            x_q <= y_q; y_q <= -x_q; ang_q <= Quarter;
          end else begin
            x_q <= -y_q; y_q <= x_q; ang_q <= -Quarter;
          end
        end else begin
          ang_q <= '0;
        end
      end
      if (cmd_i.step && !sts_o.cordic_done) begin
        it_q <= it_q + 1'b1;
        if (y_q > 0) begin
          x_q <= x_q + dx; y_q <= y_q - dy; ang_q <= ang_q + atan_lut(5'(it_q));
        end else begin
          x_q <= x_q - dx; y_q <= y_q + dy; ang_q <= ang_q - atan_lut(5'(it_q));
        end
      end
      if (cmd_i.round) begin
        if (zero_q) acc_q <= '0;
        else if (ang_r > AngMax) acc_q <= 17'sd46080;
        else if (ang_r < -AngMax) acc_q <= -17'sd46080;
        else acc_q <= 17'(ang_r);
      end
      if (cmd_i.fuse) begin
        num_q <= 40'(prev_q * 40'sd324225) + 40'(gx_q * 40'sd6336) + 40'(acc_q * 40'sd3275);
      end
      // magnitude split, estimate quotient, remainder, one correction step
      if (cmd_i.div) begin
        case (ph_q)
          2'd0: begin
            neg_q <= num_adj[40];
            a_q <= num_abs[33:2];
            lo_q <= |num_abs[1:0];
          end
          2'd1: quo_q <= qe_prod[47:32];
          2'd2: rem_q <= rem_full[17:0];
          default: begin
            if (rem_q >= 18'(Div81875)) begin
              quo_q <= quo_q + 1'b1;
              rem_q <= rem_q - 18'(Div81875);
            end
          end
        endcase
        ph_q <= ph_q + 1'b1;
      end
      if (cmd_i.err) begin
        // floor for negative numerators
        if (neg_q) begin
          if (quo_up > 17'd46080) cur_q <= -17'sd46080;
          else cur_q <= -$signed(quo_up);
        end else begin
          if (quo_q > 16'd46080) cur_q <= 17'sd46080;
          else cur_q <= $signed(17'(quo_q));
        end
      end
      if (cmd_i.integ) begin
        err_q <= 18'(cur_q) - 18'(target_angle_i);
      end
      if (cmd_i.total) begin
        if (integ_sum > 41'(IntMax)) integ_q <= IntMax;
        else if (integ_sum < 41'(IntMin)) integ_q <= IntMin;
        else integ_q <= integ_sum[39:0];
        pterm_q <= 40'($signed({1'b0, prop_gain_i})) * 40'(err_q);
        dterm_q <= 40'($signed({1'b0, deriv_gain_i})) * 40'(dang);
        prev_q <= cur_q;
        lim_q <= $signed(50'(power_limit_i) * 50'(UnitPwr));
      end
      if (cmd_i.clamp) begin
        total_q <= 50'(pterm_q * 50'sd100) + 50'(integ_q) + 50'(dterm_q * 50'sd10000);
      end
      if (cmd_i.mag) begin
        rev_q <= (total_q < 0) && (lim_q != '0);
        if (total_q > lim_q || -total_q > lim_q) mag_q <= power_limit_i;
        else mag_q <= mag_prod[26:19];
      end
    end
  end

  assign sts_o.cordic_done = (it_q == StepW'(CordicSteps));
  assign sts_o.div_done = (ph_q == 2'd3);
  assign drive_magnitude_o = motors_disabled_i ? 8'd0 : mag_q;
  assign drive_reverse_o = rev_q;
  assign tilt_angle_o = prev_q;

endmodule

// ===== rtl/core/tilt_filter_pid_controller_core.sv =====
// tilt_filter_pid_controller_core: top level, config registers, controller and datapath
// each beat steps through cordic, filter fusion, reciprocal divide and pid states
// one beat in flight at a time; next beat accepted as the result beat is taken
// asynchronous active-low reset clears state and integrator, sets config defaults
// depends on tfpid_pkg, tfpid_ctrl, tfpid_dp

module tilt_filter_pid_controller_core import tfpid_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic signed [15:0] gyro_x_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         drive_magnitude_o,
  output logic               drive_reverse_o,
  output logic signed [16:0] tilt_angle_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  logic [15:0]        prop_q, integ_q, deriv_q;
  logic signed [16:0] target_q;
  logic [7:0]         limit_q;
  logic               dis_q;
  dp_cmd_t            cmd;
  dp_sts_t            sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_q <= '0; integ_q <= '0; deriv_q <= '0;
      target_q <= '0; limit_q <= 8'd100; dis_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PROP:   prop_q <= cfg_data_i[15:0];
        CFG_INTEG:  integ_q <= cfg_data_i[15:0];
        CFG_DERIV:  deriv_q <= cfg_data_i[15:0];
        CFG_TARGET: target_q <= cfg_data_i[16:0];
        CFG_LIMIT:  limit_q <= cfg_data_i[7:0];
        CFG_DIS:    dis_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  tfpid_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  tfpid_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .accel_y_i, .accel_z_i, .gyro_x_i,
    .prop_gain_i(prop_q), .integ_gain_i(integ_q), .deriv_gain_i(deriv_q),
    .target_angle_i(target_q), .power_limit_i(limit_q), .motors_disabled_i(dis_q),
    .drive_magnitude_o, .drive_reverse_o, .tilt_angle_o
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o || !out_stall_i) else $error("accept while result held");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dis_q && out_valid_o |-> drive_magnitude_o == 8'd0) else $error("disabled drive");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> drive_magnitude_o <= limit_q || dis_q) else $error("limit exceeded");

endmodule

// ===== test/tb_top.sv =====
// tb_top: self-checking testbench for tilt_filter_pid_controller_core
// predicts each drive beat with a fixed-point copy of the filter and pid, checks it field by field
// depends on tfpid_pkg and tilt_filter_pid_controller_core

module tb_top import tfpid_pkg::*;;

  localparam logic [2:0] SPARE_IDX_A = 3'd6;
  localparam logic [2:0] SPARE_IDX_B = 3'd7;
  localparam longint TILT_LIMIT = 46080;
  localparam longint INTEG_HI = 64'sd549755813887;
  localparam longint INTEG_LO = -64'sd549755813888;
  localparam longint DRIVE_UNIT = 6553600;

  typedef struct {
    logic [7:0]         magnitude;
    logic               reverse;
    logic signed [16:0] angle;
  } drive_beat_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic signed [15:0] accel_y, accel_z, gyro_x;
  logic out_valid, out_stall;
  logic [7:0] drive_magnitude;
  logic drive_reverse;
  logic signed [16:0] tilt_angle;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  // shadow registers and state
  longint gain_p, gain_i, gain_d, setpoint_bits, drive_limit, motors_off;
  longint last_tilt, integ_acc;

  drive_beat_t pending_drive[$];
  int error_count;
  int stall_stretch;
  bit steady;

  longint arctan_tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                              14668, 7334, 3667, 1833, 917, 458, 229, 115,
                              57, 29, 14, 7, 4, 2, 1, 0};

  tilt_filter_pid_controller_core DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .accel_y_i(accel_y), .accel_z_i(accel_z), .gyro_x_i(gyro_x),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .drive_magnitude_o(drive_magnitude), .drive_reverse_o(drive_reverse),
    .tilt_angle_o(tilt_angle),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if (n % d != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint accel_tilt(longint ay, longint az);
    longint x, y, ang, t, dx, dy;
    x = az * 256;
    y = ay * 256;
    ang = 0;
    if (ay == 0 && az == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; ang = 5898240;
      end else begin
        x = -y; y = t; ang = -5898240;
      end
    end
    for (int i = 0; i < CordicSteps && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; ang += arctan_tab[i];
      end else begin
        x -= dx; y += dy; ang -= arctan_tab[i];
      end
    end
    return clip((ang + 128) >>> 8, -TILT_LIMIT, TILT_LIMIT);
  endfunction

  function automatic drive_beat_t predict_drive(longint ay, longint az, longint gx);
    drive_beat_t b;
    longint acc, num, cur, err, lim, total, mag, target;
    acc = accel_tilt(ay, az);
    num = 99 * 3275 * last_tilt + 99 * 64 * gx + 3275 * acc;
    cur = clip(floor_div(num + 163750, 327500), -TILT_LIMIT, TILT_LIMIT);
    target = setpoint_bits >= 65536 ? setpoint_bits - 131072 : setpoint_bits;
    err = cur - target;
    lim = drive_limit * DRIVE_UNIT;
    integ_acc = clip(integ_acc + gain_i * err, INTEG_LO, INTEG_HI);
    total = 100 * gain_p * err + integ_acc + 10000 * gain_d * (cur - last_tilt);
    last_tilt = cur;
    total = clip(total, -lim, lim);
    b.reverse = total < 0;
    mag = b.reverse ? -total : total;
    mag = (mag + DRIVE_UNIT / 2) / DRIVE_UNIT;
    if (motors_off != 0) mag = 0;
    b.magnitude = mag[7:0];
    b.angle = cur[16:0];
    return b;
  endfunction

  // result checker
  always @(posedge clk) begin
    drive_beat_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_drive.size() == 0) begin
        $display("%0t: unexpected beat mag %0d rev %0d angle %0d", $time,
                 drive_magnitude, drive_reverse, tilt_angle);
        error_count++;
      end else begin
        e = pending_drive.pop_front();
        if (drive_magnitude !== e.magnitude) begin
          $display("%0t: drive_magnitude expected %0d actual %0d", $time, e.magnitude,
                   drive_magnitude);
          error_count++;
        end
        if (drive_reverse !== e.reverse) begin
          $display("%0t: drive_reverse expected %0d actual %0d", $time, e.reverse,
                   drive_reverse);
          error_count++;
        end
        if (tilt_angle !== e.angle) begin
          $display("%0t: tilt_angle expected %0d actual %0d", $time, e.angle, tilt_angle);
          error_count++;
        end
      end
    end
  end

  // receiver side stalls
  initial begin
    int k;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (stall_stretch > 0) begin
        k = stall_stretch;
        stall_stretch = 0;
        out_stall = 1'b1;
        repeat (k) @(negedge clk);
      end else begin
        k = steady ? 0 : $urandom_range(0, 3);
        if (k > 0) begin
          out_stall = 1'b1;
          repeat (k) @(negedge clk);
        end
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_sample(logic signed [15:0] ay, logic signed [15:0] az,
                             logic signed [15:0] gx);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    accel_y = ay;
    accel_z = az;
    gyro_x = gx;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    pending_drive.push_back(predict_drive(ay, az, gx));
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_drive.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PROP:   gain_p = data[15:0];
      CFG_INTEG:  gain_i = data[15:0];
      CFG_DERIV:  gain_d = data[15:0];
      CFG_TARGET: setpoint_bits = data[16:0];
      CFG_LIMIT:  drive_limit = data[7:0];
      CFG_DIS:    motors_off = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic setup_pid(int p, int i, int d, int target, int limit, int off);
    write_reg(CFG_PROP, {16'($urandom), p[15:0]});
    write_reg(CFG_INTEG, {16'($urandom), i[15:0]});
    write_reg(CFG_DERIV, {16'($urandom), d[15:0]});
    write_reg(CFG_TARGET, {15'($urandom), target[16:0]});
    write_reg(CFG_LIMIT, {24'($urandom), limit[7:0]});
    write_reg(CFG_DIS, {31'($urandom), off[0]});
  endtask

  task automatic send_random_sample;
    real theta, r;
    int ay, az;
    if ($urandom_range(0, 9) < 2) begin
      send_sample(16'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      theta = real'(int'($urandom_range(0, 35999)) - 18000) * 3.14159265 / 18000.0;
      r = 12000.0 + $urandom_range(0, 8000);
      ay = $rtoi(r * $sin(theta));
      az = $rtoi(r * $cos(theta));
      send_sample(16'(ay), 16'(az), 16'(int'($urandom_range(0, 4000)) - 2000));
    end
  endtask

  task automatic test_directed;
    setup_pid(16'h0200, 16'h0004, 16'h0010, 0, 100, 0);
    send_sample(0, 0, 0);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_sample(-16'sh8000, -16'sh8000, -16'sh8000);
    send_sample(0, -100, 0);
    send_sample(-100, -100, 0);
    send_sample(100, -100, 0);
    send_sample(100, 0, 0);
    send_sample(-100, 0, 0);
    send_sample(0, 16384, 0);
    send_sample(16'sh7fff, 0, 16'sh7fff);
    send_sample(-16'sh8000, 0, -16'sh8000);
    drain();
    // small negative error rounds to zero magnitude
    setup_pid(1, 0, 0, 2000, 255, 0);
    send_sample(0, 16384, 0);
    send_sample(0, 16384, 0);
    drain();
    // disabled motors, setpoint pattern beyond the angle range, spare indexes
    write_reg(SPARE_IDX_A, 32'hffff_ffff);
    write_reg(SPARE_IDX_B, 32'h0000_0001);
    setup_pid(16'hffff, 16'hffff, 16'hffff, 17'h10000, 255, 1);
    send_sample(16384, 0, 1000);
    send_sample(-16384, 0, -1000);
    drain();
    setup_pid(16'hffff, 16'hffff, 16'hffff, 17'h0ffff, 0, 0);
    send_sample(16384, 16384, 0);
    send_sample(-16384, -16384, 0);
    drain();
  endtask

  task automatic test_random_settings;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: setup_pid(0, 0, 0, 0, 0, 0);
        1: setup_pid(16'hffff, 16'hffff, 16'hffff, -46080, 255, 0);
        2: setup_pid(16'hffff, 16'hffff, 16'hffff, 46080, 255, 1);
        default: setup_pid($urandom_range(0, 2047), $urandom_range(0, 63),
                           $urandom_range(0, 255), $urandom_range(0, 92160) - 46080,
                           $urandom_range(0, 255), $urandom_range(0, 4) == 0);
      endcase
      steady = (phase == 4);
      repeat (250) send_random_sample();
      steady = 1'b0;
      drain();
    end
  endtask

  task automatic test_backpressure;
    setup_pid(16'h0300, 16'h0002, 16'h0020, 0, 200, 0);
    stall_stretch = 300;
    repeat (20) send_random_sample();
    repeat (200) send_random_sample();
    // sender waits until everything is out, then resumes
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_drive.size() > 0) @(posedge clk);
    repeat (80) send_random_sample();
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    accel_y = '0;
    accel_z = '0;
    gyro_x = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    error_count = 0;
    stall_stretch = 0;
    steady = 1'b0;
    gain_p = 0; gain_i = 0; gain_d = 0; setpoint_bits = 0;
    drive_limit = 100; motors_off = 0;
    last_tilt = 0; integ_acc = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (80) @(posedge clk);
    test_directed();
    test_random_settings();
    test_backpressure();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tfpid_pkg.sv
rtl/core/tfpid_ctrl.sv
rtl/core/tfpid_dp.sv
rtl/core/tilt_filter_pid_controller_core.sv
test/tb_top.sv
